// ----- rtl/core/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; no dependencies.
package ffba_pkg;

	localparam int DATA_W     = 32;
	localparam int MAX_BLOCKS = 64;
	localparam int ALIGN_LOG2 = 12;
	localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

	// block count holds 0..MAX_BLOCKS; a cell index holds 0..MAX_BLOCKS-1
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	// register indexes of the configuration port
	localparam logic REG_REGION_BASE = 1'b0;
	localparam logic REG_REGION_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_EVAL,
		S_PICK,
		S_SEARCH,
		S_MATCH,
		S_APPLY
	} state_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              calc_end;   // latch start+length, clear selection
		logic              eval;       // latch gap and address compares
		logic              pick_alloc; // latch first-fit selection
		logic              pick_ext;   // latch selection from address lookup
		logic              commit;     // apply insert or remove
		logic              insert;     // 1 insert at selection, 0 remove it
		logic [DATA_W-1:0] rounded;
		logic [DATA_W-1:0] region_end;
		logic [DATA_W-1:0] addr;
	} ffba_ctrl_t;

	// what a cell hands to its neighbors
	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] length;
		logic [DATA_W-1:0] end_addr;
		logic              hit;        // a fitting place lies at or before this cell
		logic              after;      // selection lies at or before this cell
	} ffba_link_t;

endpackage

// ----- rtl/core/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: sequencer, counters and the row of cells.
// Depends on ffba_pkg and ffba_cell.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   in       | in_valid / in_stall    | opcode, request_size, target_addr
//   out      | out_valid / out_stall  | alloc_addr, status, found_size, used_total
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction at a time. Allocate steps through round, gap compare in every cell,
// first-fit pick along the row, then shift and commit as its result is registered.
// Free and query run a binary search that probes one compare bit of the row per cycle;
// an unknown opcode goes from the round step straight to its failing result.
// Reset empties the table and clears both registers; no clearing pass is needed.
// A result held by out_stall keeps the next transaction in its commit cycle.
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [DATA_W-1:0] request_size,
	input  logic [DATA_W-1:0] target_addr,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] alloc_addr,
	output logic              status,
	output logic [DATA_W-1:0] found_size,
	output logic [DATA_W-1:0] used_total,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam logic [DATA_W:0] ALIGN_MASK = (DATA_W + 1)'(ALIGN_BYTES - 1);

	state_t state_q, state_d;

	opcode_t           op_q;
	logic [DATA_W-1:0] size_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] rounded_q;
	logic              ovf_q;
	logic [DATA_W-1:0] region_end_q;
	logic              pre_ok_q;
	logic              hit_q;
	logic              found_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] used_q;
	logic [DATA_W-1:0] region_base_q;
	logic [DATA_W-1:0] region_size_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] alloc_addr_q;
	logic              status_q;
	logic [DATA_W-1:0] found_size_q;
	logic [DATA_W-1:0] used_total_q;

	ffba_ctrl_t        ctrl;
	ffba_link_t        link [0:MAX_BLOCKS+1];
	logic [MAX_BLOCKS-1:0] occ;
	logic [MAX_BLOCKS-1:0] sel_vec;
	logic [MAX_BLOCKS-1:0] lt_vec;
	logic [MAX_BLOCKS-1:0] eq_vec;
	logic [MAX_BLOCKS-1:0] pick_vec;
	logic [DATA_W-1:0] cand_part [0:MAX_BLOCKS-1];
	logic [DATA_W-1:0] len_part  [0:MAX_BLOCKS-1];
	logic [DATA_W-1:0] cand_sel;
	logic [DATA_W-1:0] len_sel;

	logic [DATA_W:0]   rounded_wide;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic              lookup_hit;
	logic              out_free;
	logic              alloc_ok;
	logic              commit;

	// round the request up to the alignment
	assign rounded_wide = ({1'b0, size_q} + ALIGN_MASK) & ~ALIGN_MASK;

	// probe point of the binary search
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];

	assign lookup_hit = (lo_q < count_q) && eq_vec[lo_q[IDX_W-1:0]];
	assign out_free   = !out_valid_q || !out_stall;
	assign alloc_ok   = pre_ok_q && hit_q;
	assign commit     = (state_q == S_APPLY) && out_free &&
	                    (((op_q == OP_ALLOC) && alloc_ok) || ((op_q == OP_FREE) && found_q));

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell controls
	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.rounded    = rounded_q;
		ctrl.region_end = region_end_q;
		ctrl.addr       = addr_q;
		ctrl.insert     = (op_q == OP_ALLOC);
		ctrl.commit     = commit;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				ctrl.calc_end = 1'b1;
				case (op_q)
					OP_ALLOC, OP_FREE, OP_QUERY: state_d = S_EVAL;
					default:                     state_d = S_APPLY;
				endcase
			end
			S_EVAL: begin
				ctrl.eval = 1'b1;
				state_d   = (op_q == OP_ALLOC) ? S_PICK : S_SEARCH;
			end
			S_PICK: begin
				ctrl.pick_alloc = 1'b1;
				state_d         = S_APPLY;
			end
			S_SEARCH: begin
				if (lo_q >= hi_q) begin
					state_d = S_MATCH;
				end
			end
			S_MATCH: begin
				ctrl.pick_ext = 1'b1;
				state_d       = S_APPLY;
			end
			S_APPLY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// hold the registers of the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			region_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REGION_BASE: region_base_q <= cfg_data;
				REG_REGION_SIZE: region_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latch the transaction and per-step working values
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= opcode_t'(opcode);
			size_q <= request_size;
			addr_q <= target_addr;
		end
		if (state_q == S_PREP) begin
			rounded_q    <= rounded_wide[DATA_W-1:0];
			ovf_q        <= rounded_wide[DATA_W];
			region_end_q <= region_base_q + region_size_q;
		end
		if (state_q == S_EVAL) begin
			pre_ok_q <= (size_q != '0) && (count_q < CNT_W'(MAX_BLOCKS)) && !ovf_q &&
			            (rounded_q != '0) && (rounded_q <= region_size_q);
			lo_q     <= '0;
			hi_q     <= count_q;
		end
		if (state_q == S_PICK) begin
			hit_q <= link[MAX_BLOCKS].hit;
		end
		if (state_q == S_SEARCH && lo_q < hi_q) begin
			if (lt_vec[mid[IDX_W-1:0]]) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (state_q == S_MATCH) begin
			found_q <= lookup_hit;
		end
	end

	// one-hot of the looked-up entry
	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			pick_vec[i] = lookup_hit && (lo_q == CNT_W'(i));
			occ[i]      = CNT_W'(i) < count_q;
		end
	end

	// gather the selected entry's start and length
	always_comb begin
		cand_sel = '0;
		len_sel  = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			cand_sel = cand_sel | cand_part[i];
			len_sel  = len_sel | len_part[i];
		end
	end

	// row of cells
	assign link[0].start    = '0;
	assign link[0].length   = '0;
	assign link[0].end_addr = region_base_q;
	assign link[0].hit      = 1'b0;
	assign link[0].after    = 1'b0;
	assign link[MAX_BLOCKS+1] = '0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		ffba_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.occ       (occ[g]),
			.occ_prev  ((g == 0) ? 1'b1 : occ[(g == 0) ? 0 : g-1]),
			.left_in   (link[g]),
			.right_in  (link[g+2]),
			.right_out (link[g+1]),
			.pick_ext  (pick_vec[g]),
			.sel       (sel_vec[g]),
			.lt        (lt_vec[g]),
			.eq        (eq_vec[g]),
			.cand_part (cand_part[g]),
			.len_part  (len_part[g])
		);
	end

	// update the block count and byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
		end else if (commit) begin
			if (op_q == OP_ALLOC) begin
				count_q <= count_q + CNT_W'(1);
				used_q  <= used_q + rounded_q;
			end else begin
				count_q <= count_q - CNT_W'(1);
				used_q  <= used_q - len_sel;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_APPLY && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY && out_free) begin
			case (op_q)
				OP_ALLOC: begin
					alloc_addr_q <= alloc_ok ? cand_sel : '0;
					status_q     <= alloc_ok ? 1'b0 : 1'b1;
					found_size_q <= '0;
					used_total_q <= alloc_ok ? (used_q + rounded_q) : used_q;
				end
				OP_FREE: begin
					alloc_addr_q <= '0;
					status_q     <= found_q ? 1'b0 : 1'b1;
					found_size_q <= '0;
					used_total_q <= found_q ? (used_q - len_sel) : used_q;
				end
				OP_QUERY: begin
					alloc_addr_q <= '0;
					status_q     <= found_q ? 1'b0 : 1'b1;
					found_size_q <= found_q ? len_sel : '0;
					used_total_q <= used_q;
				end
				default: begin
					alloc_addr_q <= '0;
					status_q     <= 1'b1;
					found_size_q <= '0;
					used_total_q <= used_q;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;
	assign found_size = found_size_q;
	assign used_total = used_total_q;

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count above table depth");

	// at most one entry selected when committing
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $onehot0(sel_vec))
		else $error("more than one cell selected");

	// an allocate commit grows the table by one
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == OP_ALLOC) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("allocate did not add one block");

	// a free commit shrinks the table by one
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == OP_FREE) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("free did not remove one block");

endmodule

// ----- rtl/core/ffba_cell.sv -----
// One table entry of the allocator: start, length and per-entry compares.
// Depends on ffba_pkg; instantiated in a row by first_fit_block_allocator.
module ffba_cell import ffba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ffba_ctrl_t          ctrl,
	input  logic                occ,
	input  logic                occ_prev,
	input  ffba_link_t          left_in,
	input  ffba_link_t          right_in,
	output ffba_link_t          right_out,
	input  logic                pick_ext,
	output logic                sel,
	output logic                lt,
	output logic                eq,
	output logic [DATA_W-1:0]   cand_part,
	output logic [DATA_W-1:0]   len_part
);

	logic [DATA_W-1:0] start_q;
	logic [DATA_W-1:0] length_q;
	logic [DATA_W-1:0] end_q;
	logic              fit_q;
	logic              tail_fit_q;
	logic              lt_q;
	logic              eq_q;
	logic              sel_q;

	logic [DATA_W-1:0] gap;
	logic [DATA_W-1:0] tail_gap;
	logic              cand_ok;
	logic              sel_d;

	// gaps measured from the end of the left neighbor
	assign gap      = start_q - left_in.end_addr;
	assign tail_gap = ctrl.region_end - left_in.end_addr;

	// an occupied entry fits by its own gap, the first free entry by the tail gap
	assign cand_ok = occ ? fit_q : (occ_prev & tail_fit_q);
	assign sel_d   = ctrl.pick_alloc ? (cand_ok & ~left_in.hit) : pick_ext;

	// hold the selection flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (ctrl.calc_end) begin
			sel_q <= 1'b0;
		end else if (ctrl.pick_alloc || ctrl.pick_ext) begin
			sel_q <= sel_d;
		end
	end

	// latch compares
	always_ff @(posedge clk) begin
		if (ctrl.calc_end) begin
			end_q <= start_q + length_q;
		end
		if (ctrl.eval) begin
			fit_q      <= (gap >= ctrl.rounded);
			tail_fit_q <= (tail_gap >= ctrl.rounded);
			lt_q       <= (start_q < ctrl.addr);
			eq_q       <= (start_q == ctrl.addr);
		end
	end

	// shift entries: right on insert, left on remove
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			if (ctrl.insert) begin
				if (sel_q) begin
					start_q  <= left_in.end_addr;
					length_q <= ctrl.rounded;
				end else if (left_in.after) begin
					start_q  <= left_in.start;
					length_q <= left_in.length;
				end
			end else if (sel_q || left_in.after) begin
				start_q  <= right_in.start;
				length_q <= right_in.length;
			end
		end
	end

	assign right_out.start    = start_q;
	assign right_out.length   = length_q;
	assign right_out.end_addr = end_q;
	assign right_out.hit      = left_in.hit | cand_ok;
	assign right_out.after    = left_in.after | sel_q;

	assign sel       = sel_q;
	assign lt        = lt_q;
	assign eq        = eq_q;
	assign cand_part = sel_q ? left_in.end_addr : '0;
	assign len_part  = sel_q ? length_q : '0;

endmodule

// ----- tb/first_fit_block_allocator_sb.sv -----
`timescale 1ns / 1ps
// Scoreboard for the first-fit block allocator: a predictor of the block table and
// a queue of expected results. Depends on ffba_pkg.
package ffba_check_pkg;
	import ffba_pkg::*;

	// opcode with no meaning; the block must refuse it
	localparam logic [1:0] OP_UNDEF = 2'd3;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct {
		logic [DATA_W-1:0] addr;
		logic              status;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] used;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [DATA_W-1:0] rgn_base;
		logic [DATA_W-1:0] rgn_len;
		logic [DATA_W-1:0] blk_start[MAX_BLOCKS];
		logic [DATA_W-1:0] blk_len[MAX_BLOCKS];
		int                nblk;
		logic [DATA_W-1:0] bytes_used;
		alloc_result_t     awaiting[$];
		int errors, checked, alloc_ok, alloc_fail, full_rejects, free_hits, query_hits;

		function new();
			rgn_base   = '0;
			rgn_len    = '0;
			nblk       = 0;
			bytes_used = '0;
		endfunction

		function void set_region(logic idx, logic [DATA_W-1:0] data);
			if (idx == REG_REGION_BASE) begin
				rgn_base = data;
			end else begin
				rgn_len = data;
			end
		endfunction

		// lower-bound search on start addresses, then exact match
		function int find_block(logic [DATA_W-1:0] a);
			int lo, hi, mid;
			lo = 0;
			hi = nblk;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (blk_start[mid] < a) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			if (lo < nblk && blk_start[lo] == a)
				return lo;
			return -1;
		endfunction

		// round up, take the first gap that fits, insert in table order
		function bit place_block(logic [DATA_W-1:0] req, output logic [DATA_W-1:0] where);
			logic [DATA_W:0]   wide;
			logic [DATA_W-1:0] rnd, cand, rend, gap;
			int                ins, i;
			where = '0;
			if (req == '0)
				return 0;
			if (nblk >= MAX_BLOCKS) begin
				full_rejects++;
				return 0;
			end
			wide = {1'b0, req} + (DATA_W + 1)'(ALIGN_BYTES - 1);
			wide[ALIGN_LOG2-1:0] = '0;
			rnd = wide[DATA_W-1:0];
			if (wide[DATA_W] || rnd == '0 || rnd > rgn_len)
				return 0;
			rend = rgn_base + rgn_len;
			cand = rgn_base;
			ins  = nblk;
			for (i = 0; i < nblk; i++) begin
				gap = blk_start[i] - cand;
				if (gap >= rnd) begin
					ins = i;
					break;
				end
				cand = blk_start[i] + blk_len[i];
			end
			gap = rend - cand;
			if (ins == nblk && gap < rnd)
				return 0;
			for (i = nblk; i > ins; i--) begin
				blk_start[i] = blk_start[i-1];
				blk_len[i]   = blk_len[i-1];
			end
			blk_start[ins] = cand;
			blk_len[ins]   = rnd;
			nblk++;
			bytes_used += rnd;
			where = cand;
			return 1;
		endfunction

		// advance the predicted table by one accepted transaction
		function void note_request(logic [1:0] op, logic [DATA_W-1:0] req,
				logic [DATA_W-1:0] target);
			alloc_result_t     r;
			logic [DATA_W-1:0] where;
			int                k, i;
			r.addr   = '0;
			r.status = ST_FAIL;
			r.size   = '0;
			case (op)
				OP_ALLOC: begin
					if (place_block(req, where)) begin
						r.addr   = where;
						r.status = ST_OK;
						alloc_ok++;
					end else begin
						alloc_fail++;
					end
				end
				OP_FREE: begin
					k = find_block(target);
					if (k >= 0) begin
						bytes_used -= blk_len[k];
						for (i = k; i + 1 < nblk; i++) begin
							blk_start[i] = blk_start[i+1];
							blk_len[i]   = blk_len[i+1];
						end
						nblk--;
						r.status = ST_OK;
						free_hits++;
					end
				end
				OP_QUERY: begin
					k = find_block(target);
					if (k >= 0) begin
						r.size   = blk_len[k];
						r.status = ST_OK;
						query_hits++;
					end
				end
				default: ;
			endcase
			r.used = bytes_used;
			awaiting.push_back(r);
		endfunction

		function void cmp_field(string fname, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %h, actual %h", fname, want, got);
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [DATA_W-1:0] a, logic st, logic [DATA_W-1:0] fs,
				logic [DATA_W-1:0] ut);
			alloc_result_t want;
			if (awaiting.size() == 0) begin
				errors++;
				$error("result with no request pending: alloc_addr %h status %b found_size %h used_total %h",
					a, st, fs, ut);
				return;
			end
			want = awaiting.pop_front();
			checked++;
			cmp_field("alloc_addr", want.addr, a);
			cmp_field("status", want.status, st);
			cmp_field("found_size", want.size, fs);
			cmp_field("used_total", want.used, ut);
		endfunction

		function int pending();
			return awaiting.size();
		endfunction

		function logic [DATA_W-1:0] pick_start();
			if (nblk == 0)
				return $urandom;
			return blk_start[$urandom_range(nblk - 1)];
		endfunction
	endclass

endpackage

// ----- tb/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator: directed and random transactions
// under random idling, checked against the scoreboard. Depends on ffba_pkg, ffba_check_pkg.
module first_fit_block_allocator_tb;
	import ffba_pkg::*;
	import ffba_check_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        opcode;
	logic [DATA_W-1:0] request_size;
	logic [DATA_W-1:0] target_addr;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] alloc_addr;
	logic              status;
	logic [DATA_W-1:0] found_size;
	logic [DATA_W-1:0] used_total;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [DATA_W-1:0] cfg_data;

	alloc_scoreboard sb = new();

	int send_gap_pct   = 29;
	int recv_stall_pct = 29;
	bit hold_request   = 1'b0;
	int settings_seen  = 1;

	first_fit_block_allocator dut (.*);

	always #5 clk = ~clk;

	// drain results; a requested hold-off stalls the output for a long stretch
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(alloc_addr, status, found_size, used_total);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				out_stall    <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// end the run when no transaction moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$error("no transaction for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, sb.pending());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// offer one transaction after a random gap and hold it until accepted
	task automatic send_item(logic [1:0] op, logic [DATA_W-1:0] req, logic [DATA_W-1:0] target);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		request_size <= req;
		target_addr  <= target;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, req, target);
	endtask

	// drop valid and wait for every pending result
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_region(logic [DATA_W-1:0] base, logic [DATA_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_index <= REG_REGION_BASE;
		cfg_data  <= base;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_region(REG_REGION_BASE, base);
		cfg_index <= REG_REGION_SIZE;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_region(REG_REGION_SIZE, len);
		cfg_valid <= 1'b0;
	endtask

	// mostly small requests, with zero, huge and region-sized ones mixed in
	function automatic logic [DATA_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(1, 4 * ALIGN_BYTES);
		if (r < 70)
			return DATA_W'($urandom_range(1, 16) * ALIGN_BYTES);
		if (r < 80)
			return $urandom;
		if (r < 85)
			return '0;
		if (r < 90)
			return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 2 * ALIGN_BYTES));
		return sb.rgn_len + DATA_W'($urandom_range(0, 2 * ALIGN_BYTES)) - DATA_W'(ALIGN_BYTES);
	endfunction

	// mostly live block starts, some near misses, some noise
	function automatic logic [DATA_W-1:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (sb.nblk == 0 || r >= 85)
			return $urandom;
		if (r >= 80)
			return sb.pick_start() + 1;
		if (r >= 75)
			return sb.pick_start() - 1;
		return sb.pick_start();
	endfunction

	// free live blocks until the table is empty or the search keeps missing
	task automatic release_all();
		int tries;
		tries = 0;
		while (sb.nblk > 0 && tries < 3 * MAX_BLOCKS) begin
			send_item(OP_FREE, $urandom, sb.pick_start());
			tries++;
		end
	endtask

	task automatic run_phase(logic [DATA_W-1:0] base, logic [DATA_W-1:0] len, int alloc_w,
			int free_w, int n, int hold_at, bit clear_after);
		int         i, r;
		logic [1:0] op;
		quiesce();
		write_region(base, len);
		settings_seen++;
		for (i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			r = $urandom_range(99);
			if (r < alloc_w)
				op = OP_ALLOC;
			else if (r < alloc_w + free_w)
				op = OP_FREE;
			else if (r < 97)
				op = OP_QUERY;
			else
				op = OP_UNDEF;
			send_item(op, pick_size(), pick_target());
		end
		if (clear_after)
			release_all();
	endtask

	initial begin
		in_valid     <= 1'b0;
		opcode       <= OP_ALLOC;
		request_size <= '0;
		target_addr  <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_REGION_BASE;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty region after reset: everything is refused
		send_item(OP_ALLOC, 32'd1, '0);
		send_item(OP_QUERY, '0, '0);
		send_item(OP_FREE, '0, 32'hFFFF_FFFF);
		send_item(OP_UNDEF, '0, '0);

		// directed cases on a 1 MiB region
		quiesce();
		write_region(32'h1000_0000, 32'h0010_0000);
		send_item(OP_ALLOC, '0, '0);                           // zero request
		send_item(OP_ALLOC, 32'd1, '0);
		send_item(OP_ALLOC, DATA_W'(ALIGN_BYTES), '0);
		send_item(OP_ALLOC, DATA_W'(ALIGN_BYTES + 1), '0);    // rounds to two pages
		send_item(OP_ALLOC, 32'hFFFF_FFFF, '0);               // rounding overflow
		send_item(OP_ALLOC, 32'hFFFF_F000, '0);               // larger than region
		send_item(OP_ALLOC, 32'h0010_0001, '0);
		send_item(OP_QUERY, '0, 32'h1000_1000);
		send_item(OP_QUERY, '0, 32'h1000_1001);               // not a block start
		send_item(OP_FREE, '0, 32'h1000_1000);
		send_item(OP_FREE, '0, 32'h1000_1000);                // already freed
		send_item(OP_ALLOC, DATA_W'(2 * ALIGN_BYTES), '0);    // skips the one-page hole
		send_item(OP_ALLOC, DATA_W'(ALIGN_BYTES), '0);        // fills the hole
		send_item(OP_ALLOC, 32'h000F_0000, '0);
		send_item(OP_ALLOC, 32'h0001_0000, '0);               // no gap fits
		send_item(OP_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 32'h1000_0000);
		send_item(OP_QUERY, '0, 32'h1000_6000);
		send_item(OP_FREE, '0, '0);
		send_item(OP_FREE, '0, 32'h1000_6000);

		// random phases over several region settings
		run_phase(32'h1000_0000, 32'h0010_0000, 45, 35, 260, -1, 1'b0);
		run_phase(32'h0000_0000, 32'hFFFF_FFFF, 70, 20, 260, -1, 1'b1);
		run_phase(32'hFFFF_0000, 32'h0004_0000, 50, 30, 260, -1, 1'b1);
		run_phase(32'hFFFF_FFFF, 32'h0000_3001, 50, 30, 150, -1, 1'b1);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_phase(32'h0000_0123, 32'h0080_0000, 50, 30, 330, 60, 1'b1);
		send_gap_pct   = 29;
		recv_stall_pct = 29;
		run_phase(32'h8000_0000, 32'h0002_0000, 60, 25, 300, -1, 1'b0);

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results over %0d region settings, wrapping and unaligned ones included.",
			sb.checked, settings_seen);
		$display("Allocations: %0d placed, %0d refused (%0d on a full table); %0d frees, %0d queries hit.",
			sb.alloc_ok, sb.alloc_fail, sb.full_rejects, sb.free_hits, sb.query_hits);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- first_fit_block_allocator.f -----
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/first_fit_block_allocator.sv
tb/first_fit_block_allocator_sb.sv
tb/first_fit_block_allocator_tb.sv
